>>> design/cdft_pkg.sv
package cdft_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int TWIDDLE_BITS = 16;
	localparam int BIN_BITS     = 21;
	localparam int POINTS       = 16;

	localparam int TW_M = TWIDDLE_BITS - 1;
	localparam int PRE_W = SAMPLE_BITS + 3;
	localparam int FIN_W = SAMPLE_BITS + 6;
	localparam int PROD_W = PRE_W + TWIDDLE_BITS + 2;

	// floor(c * 2^32) of cos(pi/8), cos(pi/4), sin(pi/8)
	localparam logic [63:0] Q32_C1 = 64'h00000000EC835E79;
	localparam logic [63:0] Q32_C2 = 64'h00000000B504F333;
	localparam logic [63:0] Q32_C3 = 64'h0000000061F78A9A;
	localparam logic [63:0] Q32_HALF = 64'd1 << (31 - TW_M);

	typedef logic signed [SAMPLE_BITS-1:0] smp_t;
	typedef logic signed [PRE_W-1:0]       pre_t;
	typedef logic signed [FIN_W-1:0]       fin_t;
	typedef logic signed [BIN_BITS-1:0]    bin_t;
	typedef logic signed [TWIDDLE_BITS:0]  coef_t;
	typedef logic signed [PROD_W-1:0]      prod_t;

	localparam coef_t K1 = coef_t'((Q32_C1 + Q32_HALF) >> (32 - TW_M));
	localparam coef_t K2 = coef_t'((Q32_C2 + Q32_HALF) >> (32 - TW_M));
	localparam coef_t K3 = coef_t'((Q32_C3 + Q32_HALF) >> (32 - TW_M));
	localparam prod_t RND = prod_t'(64'd1 << (TW_M - 1));

	typedef struct packed {
		logic valid;
		logic inverse;
	} tok_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CALC,
		BK_OUT
	} bk_state_t;

	// round((ka*x + kb*y) / 2^M), ties up
	function automatic fin_t rot(input pre_t x, input coef_t ka, input pre_t y, input coef_t kb);
		prod_t s;
		s = prod_t'(x) * prod_t'(ka) + prod_t'(y) * prod_t'(kb) + RND;
		return fin_t'(s >>> TW_M);
	endfunction

endpackage

>>> design/cdft_front.sv
module cdft_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  cdft_pkg::smp_t       sample_real,
	input  cdft_pkg::smp_t       sample_imag,
	input  logic                 inverse_mode,
	input  logic                 take,
	output cdft_pkg::tok_t       tok,
	output cdft_pkg::smp_t       frame_re [cdft_pkg::POINTS],
	output cdft_pkg::smp_t       frame_im [cdft_pkg::POINTS]
);
	import cdft_pkg::*;

	smp_t bank_re_q [2][POINTS];
	smp_t bank_im_q [2][POINTS];
	logic [3:0] fill_q;
	logic       wr_bank_q;
	logic       rd_bank_q;
	logic [1:0] cnt_q;
	logic [1:0] tok_inv_q;
	logic       accept;
	logic       frame_end;

	assign full      = (cnt_q == 2'd2);
	assign accept    = push && !full;
	assign frame_end = accept && (fill_q == 4'd15);

	always_ff @(posedge clk) begin
		if (accept) begin
			bank_re_q[wr_bank_q][fill_q] <= sample_real;
			bank_im_q[wr_bank_q][fill_q] <= sample_imag;
		end
		if (frame_end) begin
			tok_inv_q[wr_bank_q] <= inverse_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			wr_bank_q <= 1'b0;
			rd_bank_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (accept) begin
				fill_q <= fill_q + 4'd1;
			end
			if (frame_end) begin
				wr_bank_q <= !wr_bank_q;
			end
			if (take) begin
				rd_bank_q <= !rd_bank_q;
			end
			case ({frame_end, take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign tok.valid   = (cnt_q != 2'd0);
	assign tok.inverse = tok_inv_q[rd_bank_q];

	always_comb begin
		for (int n = 0; n < POINTS; n++) begin
			frame_re[n] = bank_re_q[rd_bank_q][n];
			frame_im[n] = bank_im_q[rd_bank_q][n];
		end
	end

	a_take_has_frame: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> cnt_q != 2'd0) else $error("frame taken from empty queue");
	a_frame_queued: assert property (@(posedge clk) disable iff (!arst_n)
		frame_end |=> cnt_q != 2'd0) else $error("completed frame not queued");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("frame queue overflow");

endmodule

>>> design/cdft_core.sv
module cdft_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic            inverse,
	input  cdft_pkg::smp_t  frame_re [cdft_pkg::POINTS],
	input  cdft_pkg::smp_t  frame_im [cdft_pkg::POINTS],
	output logic            done,
	output cdft_pkg::bin_t  res_re [cdft_pkg::POINTS],
	output cdft_pkg::bin_t  res_im [cdft_pkg::POINTS]
);
	import cdft_pkg::*;

	// stage 1: samples, real and imaginary swapped in inverse mode
	smp_t xr_s1 [POINTS];
	smp_t xi_s1 [POINTS];
	logic v_s1, v_s2, v_s3, v_s4;

	always_ff @(posedge clk) begin
		if (load) begin
			for (int n = 0; n < POINTS; n++) begin
				xr_s1[n] <= inverse ? frame_im[n] : frame_re[n];
				xi_s1[n] <= inverse ? frame_re[n] : frame_im[n];
			end
		end
	end

	// stage 2: add network ahead of rotations
	pre_t ar [8], sr [8], ai [8], si [8];
	pre_t rc1, qc1;
	pre_t p1_s2, p2_s2, p3_s2, p4_s2, g1_s2, g2_s2, g3_s2, g4_s2;
	pre_t pd17_s2, pd35_s2, pe17_s2, pe35_s2, gd17_s2, gd35_s2, ge17_s2, ge35_s2;
	pre_t m6_s2, m7_s2, n6_s2, n7_s2;
	pre_t h1i_s2, h2i_s2, h3i_s2, h4i_s2;
	pre_t rc2_s2, qc2_s2, r26_s2, q26_s2, r49_s2, q49_s2, u5_s2, w5_s2;
	pre_t sr4_s2, si4_s2, w8_s2, u8_s2;

	always_comb begin
		ar[0] = '0; sr[0] = '0; ai[0] = '0; si[0] = '0;
		for (int n = 1; n < 8; n++) begin
			ar[n] = pre_t'(xr_s1[n]) + pre_t'(xr_s1[POINTS-n]);
			sr[n] = pre_t'(xr_s1[POINTS-n]) - pre_t'(xr_s1[n]);
			ai[n] = pre_t'(xi_s1[n]) + pre_t'(xi_s1[POINTS-n]);
			si[n] = pre_t'(xi_s1[POINTS-n]) - pre_t'(xi_s1[n]);
		end
		rc1 = pre_t'(xr_s1[0]) + pre_t'(xr_s1[8]);
		qc1 = pre_t'(xi_s1[0]) + pre_t'(xi_s1[8]);
	end

	always_ff @(posedge clk) begin
		p1_s2   <= ar[1] + ar[7];
		pd17_s2 <= ar[1] - ar[7];
		pe17_s2 <= sr[1] + sr[7];
		p3_s2   <= sr[1] - sr[7];
		p2_s2   <= ar[3] + ar[5];
		pd35_s2 <= ar[3] - ar[5];
		pe35_s2 <= sr[3] + sr[5];
		p4_s2   <= sr[3] - sr[5];
		g1_s2   <= ai[1] + ai[7];
		gd17_s2 <= ai[1] - ai[7];
		ge17_s2 <= si[1] + si[7];
		g3_s2   <= si[1] - si[7];
		g2_s2   <= ai[3] + ai[5];
		gd35_s2 <= ai[3] - ai[5];
		ge35_s2 <= si[3] + si[5];
		g4_s2   <= si[3] - si[5];
		m6_s2   <= (ar[1] + ar[7]) - (ar[3] + ar[5]);
		m7_s2   <= (sr[1] - sr[7]) + (sr[3] - sr[5]);
		n7_s2   <= (si[1] - si[7]) + (si[3] - si[5]);
		n6_s2   <= (ai[1] + ai[7]) - (ai[3] + ai[5]);
		h4i_s2  <= sr[2] + sr[6];
		h1i_s2  <= ar[2] - ar[6];
		h2i_s2  <= si[2] + si[6];
		h3i_s2  <= ai[2] - ai[6];
		rc2_s2  <= pre_t'(xr_s1[0]) - pre_t'(xr_s1[8]);
		qc2_s2  <= pre_t'(xi_s1[0]) - pre_t'(xi_s1[8]);
		r26_s2  <= ar[2] + ar[6];
		q26_s2  <= ai[2] + ai[6];
		r49_s2  <= rc1 + ar[4];
		q49_s2  <= qc1 + ai[4];
		u5_s2   <= rc1 - ar[4];
		w5_s2   <= qc1 - ai[4];
		sr4_s2  <= sr[4];
		si4_s2  <= si[4];
		w8_s2   <= sr[2] - sr[6];
		u8_s2   <= si[2] - si[6];
	end

	// stage 3: rotations
	fin_t u1_s3, u10_s3, w3_s3, w11_s3, u3_s3, u11_s3, w1_s3, w10_s3;
	fin_t u6_s3, w7_s3, u7_s3, w6_s3, h1_s3, h2_s3, h3_s3, h4_s3;
	fin_t p1_s3, p2_s3, p3_s3, p4_s3, g1_s3, g2_s3, g3_s3, g4_s3;
	fin_t rc2_s3, qc2_s3, r26_s3, q26_s3, r49_s3, q49_s3, u5_s3, w5_s3;
	fin_t sr4_s3, si4_s3, w8_s3, u8_s3;

	always_ff @(posedge clk) begin
		u1_s3  <= rot(pd35_s2, K3, pd17_s2, K1);
		u10_s3 <= rot(pd17_s2, K3, -pd35_s2, K1);
		w3_s3  <= rot(pe35_s2, K1, pe17_s2, K3);
		w11_s3 <= rot(pe17_s2, K1, -pe35_s2, K3);
		u3_s3  <= rot(ge35_s2, K1, ge17_s2, K3);
		u11_s3 <= rot(ge17_s2, K1, -ge35_s2, K3);
		w1_s3  <= rot(gd35_s2, K3, gd17_s2, K1);
		w10_s3 <= rot(gd17_s2, K3, -gd35_s2, K1);
		u6_s3  <= rot(m6_s2, K2, '0, '0);
		w7_s3  <= rot(m7_s2, K2, '0, '0);
		u7_s3  <= rot(n7_s2, K2, '0, '0);
		w6_s3  <= rot(n6_s2, K2, '0, '0);
		h4_s3  <= rot(h4i_s2, K2, '0, '0);
		h1_s3  <= rot(h1i_s2, K2, '0, '0);
		h2_s3  <= rot(h2i_s2, K2, '0, '0);
		h3_s3  <= rot(h3i_s2, K2, '0, '0);
		p1_s3  <= fin_t'(p1_s2);
		p2_s3  <= fin_t'(p2_s2);
		p3_s3  <= fin_t'(p3_s2);
		p4_s3  <= fin_t'(p4_s2);
		g1_s3  <= fin_t'(g1_s2);
		g2_s3  <= fin_t'(g2_s2);
		g3_s3  <= fin_t'(g3_s2);
		g4_s3  <= fin_t'(g4_s2);
		rc2_s3 <= fin_t'(rc2_s2);
		qc2_s3 <= fin_t'(qc2_s2);
		r26_s3 <= fin_t'(r26_s2);
		q26_s3 <= fin_t'(q26_s2);
		r49_s3 <= fin_t'(r49_s2);
		q49_s3 <= fin_t'(q49_s2);
		u5_s3  <= fin_t'(u5_s2);
		w5_s3  <= fin_t'(w5_s2);
		sr4_s3 <= fin_t'(sr4_s2);
		si4_s3 <= fin_t'(si4_s2);
		w8_s3  <= fin_t'(w8_s2);
		u8_s3  <= fin_t'(u8_s2);
	end

	// stage 4: output butterflies
	fin_t rr [POINTS];
	fin_t ii [POINTS];
	fin_t ua [4], ub [4], uc [4], ud [4], wa [4], wb [4], wc [4], wd [4];
	fin_t a, b, c, d;

	always_comb begin
		ua[0] = '0; ub[0] = '0; uc[0] = '0; ud[0] = '0;
		wa[0] = '0; wb[0] = '0; wc[0] = '0; wd[0] = '0;
		ua[1] = rc2_s3 + h1_s3;  ua[2] = u5_s3;  ua[3] = rc2_s3 - h1_s3;
		ub[1] = u1_s3;           ub[2] = u6_s3;  ub[3] = u10_s3;
		uc[1] = u3_s3;           uc[2] = u7_s3;  uc[3] = u11_s3;
		ud[1] = h2_s3 + si4_s3;  ud[2] = u8_s3;  ud[3] = h2_s3 - si4_s3;
		wa[1] = qc2_s3 + h3_s3;  wa[2] = w5_s3;  wa[3] = qc2_s3 - h3_s3;
		wb[1] = w1_s3;           wb[2] = w6_s3;  wb[3] = w10_s3;
		wc[1] = w3_s3;           wc[2] = w7_s3;  wc[3] = w11_s3;
		wd[1] = h4_s3 + sr4_s3;  wd[2] = w8_s3;  wd[3] = h4_s3 - sr4_s3;

		rr[0]  = r26_s3 + r49_s3 + p1_s3 + p2_s3;
		rr[8]  = (r26_s3 + r49_s3) - (p1_s3 + p2_s3);
		ii[0]  = q26_s3 + q49_s3 + g1_s3 + g2_s3;
		ii[8]  = (q26_s3 + q49_s3) - (g1_s3 + g2_s3);
		rr[4]  = (r49_s3 - r26_s3) - (g3_s3 - g4_s3);
		rr[12] = (r49_s3 - r26_s3) + (g3_s3 - g4_s3);
		ii[4]  = (q49_s3 - q26_s3) + (p3_s3 - p4_s3);
		ii[12] = (q49_s3 - q26_s3) - (p3_s3 - p4_s3);
		for (int j = 1; j <= 3; j++) begin
			a = ua[j] + ub[j]; b = uc[j] + ud[j];
			c = wc[j] + wd[j]; d = wa[j] + wb[j];
			rr[j] = a - b; rr[POINTS-j] = a + b;
			ii[j] = d + c; ii[POINTS-j] = d - c;
			a = ua[j] - ub[j]; b = uc[j] - ud[j];
			c = wc[j] - wd[j]; d = wa[j] - wb[j];
			rr[8-j] = a - b; rr[8+j] = a + b;
			ii[8-j] = d + c; ii[8+j] = d - c;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			for (int k = 0; k < POINTS; k++) begin
				res_re[k] <= bin_t'(rr[k]);
				res_im[k] <= bin_t'(ii[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= load;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign done = v_s4;

endmodule

>>> design/cdft_back.sv
module cdft_back (
	input  logic            clk,
	input  logic            arst_n,
	input  cdft_pkg::tok_t  tok,
	output logic            take,
	input  logic            done,
	input  cdft_pkg::bin_t  res_re [cdft_pkg::POINTS],
	input  cdft_pkg::bin_t  res_im [cdft_pkg::POINTS],
	output logic            empty,
	input  logic            pop,
	output cdft_pkg::bin_t  bin_real,
	output cdft_pkg::bin_t  bin_imag,
	output logic [3:0]      bin_number,
	output logic            last_bin
);
	import cdft_pkg::*;

	bk_state_t st_q, st_d;
	logic [3:0] idx_q;
	logic       inv_q;
	logic       xfer;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (tok.valid) st_d = BK_CALC;
			BK_CALC: if (done) st_d = BK_OUT;
			BK_OUT:  if (pop && idx_q == 4'd15) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		take  = 1'b0;
		empty = 1'b1;
		unique case (st_q)
			BK_IDLE: take = tok.valid;
			BK_CALC: empty = 1'b1;
			BK_OUT:  empty = 1'b0;
			default: empty = 1'b1;
		endcase
	end

	assign xfer = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= BK_IDLE;
			idx_q <= '0;
			inv_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (take) begin
				inv_q <= tok.inverse;
				idx_q <= '0;
			end else if (xfer) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	assign bin_real   = inv_q ? res_im[idx_q] : res_re[idx_q];
	assign bin_imag   = inv_q ? res_re[idx_q] : res_im[idx_q];
	assign bin_number = idx_q;
	assign last_bin   = (idx_q == 4'd15);

	a_take_calc: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> st_q == BK_CALC) else $error("frame taken without compute");
	a_frame_out: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && idx_q == 4'd15) |=> st_q == BK_IDLE) else $error("bins after last");
	a_done_calc: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> st_q == BK_CALC) else $error("results outside compute");

endmodule

>>> design/complex_dft16_engine.sv
// channel   direction  handshake                    payload
// sample    in         push / full                  sample_real, sample_imag
// bin       out        pop / empty                  bin_real, bin_imag, bin_number, last_bin
// config    in         psel, penable, pwrite/pready  paddr, pwdata, prdata
//
// samples are taken one per cycle while full is low, into one of two frame banks
// a full frame goes through the registered add/rotate pipeline, then 16 bins leave one per transfer
// one frame is computed at a time: the next frame is taken after the last bin is popped
// full rises only when both frame banks hold frames not yet computed; stalled pops also hold back new frames
// reset clears control state and inverse_mode; bank contents stay undefined
module complex_dft16_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  cdft_pkg::smp_t        sample_real,
	input  cdft_pkg::smp_t        sample_imag,
	output logic                  empty,
	input  logic                  pop,
	output cdft_pkg::bin_t        bin_real,
	output cdft_pkg::bin_t        bin_imag,
	output logic [3:0]            bin_number,
	output logic                  last_bin,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import cdft_pkg::*;

	logic inverse_q;
	logic take;
	logic done;
	tok_t tok;
	smp_t frame_re [POINTS];
	smp_t frame_im [POINTS];
	bin_t res_re [POINTS];
	bin_t res_im [POINTS];

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, inverse_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			inverse_q <= pwdata[0];
		end
	end

	cdft_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample_real  (sample_real),
		.sample_imag  (sample_imag),
		.inverse_mode (inverse_q),
		.take         (take),
		.tok          (tok),
		.frame_re     (frame_re),
		.frame_im     (frame_im)
	);

	cdft_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.inverse  (tok.inverse),
		.frame_re (frame_re),
		.frame_im (frame_im),
		.done     (done),
		.res_re   (res_re),
		.res_im   (res_im)
	);

	cdft_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok        (tok),
		.take       (take),
		.done       (done),
		.res_re     (res_re),
		.res_im     (res_im),
		.empty      (empty),
		.pop        (pop),
		.bin_real   (bin_real),
		.bin_imag   (bin_imag),
		.bin_number (bin_number),
		.last_bin   (last_bin)
	);

endmodule
